>>> hdl/dmxm_pkg.sv
// Shared constants, types and helper functions for the DMX universe pixel mapper.
package dmxm_pkg;

    // Protocol sizing.
    localparam int SLOTS_PER_UNIVERSE = 512;
    localparam int MAX_PIXELS         = 1024;

    // Field widths fixed by the interface.
    localparam int UNI_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int PIX_W      = 10;
    localparam int LEN_W      = 11;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Channel mode codes; the unused code behaves as RGBW.
    localparam logic [MODE_W-1:0] MODE_MONO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RGB  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RGBW = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNIVERSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRIP_LENGTH   = 2'd2;

    // Bytes per light.
    localparam int BPL_W = 3;
    localparam logic [BPL_W-1:0] BPL_MONO = 3'd1;
    localparam logic [BPL_W-1:0] BPL_RGB  = 3'd3;
    localparam logic [BPL_W-1:0] BPL_RGBW = 3'd4;

    // Lights per universe for each mode.
    localparam int LPU_MONO = SLOTS_PER_UNIVERSE / 1;
    localparam int LPU_RGB  = SLOTS_PER_UNIVERSE / 3;
    localparam int LPU_RGBW = SLOTS_PER_UNIVERSE / 4;
    localparam int LPU_W    = $clog2(SLOTS_PER_UNIVERSE + 1);

    // Largest effective strip length and the widest universe span it can need.
    localparam int LEN_LIMIT = (1 << LEN_W) - 1;
    localparam int LEN_MAX   = (MAX_PIXELS < LEN_LIMIT) ? MAX_PIXELS : LEN_LIMIT;
    localparam int SPAN_MAX  = (LEN_MAX + LPU_RGBW - 1) / LPU_RGBW;
    localparam int SPAN_W    = $clog2(SPAN_MAX + 1);
    localparam int PROD_W    = SPAN_W + LPU_W;
    localparam int IDX_W     = PIX_W + 1;
    localparam int CMP_W     = (PROD_W > IDX_W) ? PROD_W : IDX_W;

    // Light assembly.
    localparam int PHASE_W    = 2;
    localparam int HELD_DEPTH = 3;

    // Mean of three bytes as a multiply by a scaled reciprocal of three.
    localparam int SUM_W       = BYTE_W + 2;
    localparam int MEAN_RECIP  = 683;
    localparam int MEAN_SHIFT  = 11;
    localparam int RECIP_W     = 10;
    localparam int MEAN_PROD_W = SUM_W + RECIP_W;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [UNI_W-1:0]  first_universe;
        logic [MODE_W-1:0] channel_mode;
        logic [LEN_W-1:0]  strip_length;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel_index;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] white;
        logic              need_mean;
    } light_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // Strip length limited to the largest supported strip.
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] strip_length);
        logic [LEN_W-1:0] limit;
        limit = LEN_W'(LEN_MAX);
        if (strip_length > limit)
            return limit;
        return strip_length;
    endfunction

    function automatic logic [BPL_W-1:0] bytes_per_light(input logic [MODE_W-1:0] mode);
        logic [BPL_W-1:0] bpl;
        unique case (mode)
            MODE_MONO: bpl = BPL_MONO;
            MODE_RGB:  bpl = BPL_RGB;
            default:   bpl = BPL_RGBW;
        endcase
        return bpl;
    endfunction

    function automatic logic [LPU_W-1:0] mode_lights(input logic [MODE_W-1:0] mode);
        logic [LPU_W-1:0] lpu;
        unique case (mode)
            MODE_MONO: lpu = LPU_W'(LPU_MONO);
            MODE_RGB:  lpu = LPU_W'(LPU_RGB);
            default:   lpu = LPU_W'(LPU_RGBW);
        endcase
        return lpu;
    endfunction

endpackage

>>> hdl/dmxm_front.sv
// Front part: tracks the packet, groups slot bytes into lights and issues pixel records.
module dmxm_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dmxm_pkg::cfg_t              cfg,
    input  logic                        in_fire,
    input  logic [dmxm_pkg::UNI_W-1:0]  universe,
    input  logic [dmxm_pkg::BYTE_W-1:0] slot_value,
    input  logic                        first_slot,
    output logic                        rec_push,
    output dmxm_pkg::light_t            rec
);
    import dmxm_pkg::*;

    logic                packet_active_reg, packet_active_next;
    logic [PIX_W-1:0]    base_pixel_reg, base_pixel_next;
    logic [LPU_W-1:0]    light_reg, light_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [BYTE_W-1:0]   held_reg [HELD_DEPTH];

    logic [BPL_W-1:0]    bpl;
    logic [LPU_W-1:0]    lpu;
    logic [LEN_W-1:0]    len;
    logic [UNI_W:0]      uni_diff;
    logic                uni_ge;
    logic                span_hi_zero;
    logic [SPAN_W-1:0]   span_d;
    logic [PROD_W-1:0]   span_prod;
    logic                in_span;
    logic                start;
    logic                active_c;
    logic [PIX_W-1:0]    base_c;
    logic [LPU_W-1:0]    light_c;
    logic [PHASE_W-1:0]  phase_c;
    logic [BPL_W-1:0]    phase_inc;
    logic                work;
    logic                complete;
    logic                store;
    logic [IDX_W-1:0]    idx;

    assign bpl = bytes_per_light(cfg.channel_mode);
    assign lpu = mode_lights(cfg.channel_mode);
    assign len = eff_len(cfg.strip_length);

    // Span check: the universe offset times lights per universe must stay below the length.
    assign uni_diff     = {1'b0, universe} - {1'b0, cfg.first_universe};
    assign uni_ge       = !uni_diff[UNI_W];
    assign span_hi_zero = (uni_diff[UNI_W-1:SPAN_W] == '0);
    assign span_d       = uni_diff[SPAN_W-1:0];
    assign span_prod    = PROD_W'(span_d) * PROD_W'(lpu);
    assign in_span      = uni_ge && span_hi_zero && (CMP_W'(span_prod) < CMP_W'(len));

    // Packet state as seen by this byte, after any restart on a first slot.
    assign start    = first_slot && in_span;
    assign active_c = first_slot ? in_span : packet_active_reg;
    assign base_c   = start ? span_prod[PIX_W-1:0] : base_pixel_reg;
    assign light_c  = start ? '0 : light_reg;
    assign phase_c  = start ? '0 : phase_reg;

    assign work      = active_c && (light_c < lpu);
    assign phase_inc = BPL_W'(phase_c) + BPL_W'(1);
    assign complete  = work && !(phase_inc < bpl);
    assign store     = work && !complete;
    assign idx       = IDX_W'(base_c) + IDX_W'(light_c);

    // Next packet state.
    always_comb
    begin
        packet_active_next = packet_active_reg;
        base_pixel_next    = base_pixel_reg;
        light_next         = light_reg;
        phase_next         = phase_reg;
        if (in_fire)
        begin
            packet_active_next = active_c;
            base_pixel_next    = base_c;
            light_next         = complete ? light_c + LPU_W'(1) : light_c;
            phase_next         = complete ? '0 : (store ? phase_inc[PHASE_W-1:0] : phase_c);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_active_reg <= 1'b0;
            base_pixel_reg    <= '0;
            light_reg         <= '0;
            phase_reg         <= '0;
            for (int i = 0; i < HELD_DEPTH; i++)
            begin
                held_reg[i] <= '0;
            end
        end
        else
        begin
            packet_active_reg <= packet_active_next;
            base_pixel_reg    <= base_pixel_next;
            light_reg         <= light_next;
            phase_reg         <= phase_next;
            if (in_fire && store)
            begin
                case (phase_c)
                    2'd0:    held_reg[0] <= slot_value;
                    2'd1:    held_reg[1] <= slot_value;
                    2'd2:    held_reg[2] <= slot_value;
                    default: ;
                endcase
            end
        end
    end

    // A completed light inside the strip becomes a pixel record.
    assign rec_push = in_fire && complete && (idx < IDX_W'(len));

    always_comb
    begin
        rec.pixel_index = idx[PIX_W-1:0];
        unique case (cfg.channel_mode)
            MODE_MONO:
            begin
                rec.red       = slot_value;
                rec.green     = slot_value;
                rec.blue      = slot_value;
                rec.white     = slot_value;
                rec.need_mean = 1'b0;
            end
            MODE_RGB:
            begin
                rec.red       = held_reg[0];
                rec.green     = held_reg[1];
                rec.blue      = slot_value;
                rec.white     = slot_value;
                rec.need_mean = 1'b1;
            end
            default:
            begin
                rec.red       = held_reg[0];
                rec.green     = held_reg[1];
                rec.blue      = held_reg[2];
                rec.white     = slot_value;
                rec.need_mean = 1'b0;
            end
        endcase
    end

endmodule

>>> hdl/dmxm_queue.sv
// Short queue of pixel records between the front and back parts.
module dmxm_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_push,
    input  dmxm_pkg::light_t   wr_rec,
    input  logic               rd_pop,
    output dmxm_pkg::light_t   rd_rec,
    output dmxm_pkg::qstat_t   stat
);
    import dmxm_pkg::*;

    light_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  head_reg, head_next;
    logic [QPTR_W-1:0]  tail_reg, tail_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    // Pointer and fill count update.
    always_comb
    begin
        head_next  = rd_pop ? head_reg + QPTR_W'(1) : head_reg;
        tail_next  = wr_push ? tail_reg + QPTR_W'(1) : tail_reg;
        count_next = count_reg;
        if (wr_push && !rd_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (!wr_push && rd_pop)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (wr_push)
            entry_reg[tail_reg] <= wr_rec;
    end

    assign rd_rec     = entry_reg[head_reg];
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

>>> hdl/dmxm_back.sv
// Back part: finishes each pixel (RGB white mean) into the result register.
module dmxm_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dmxm_pkg::qstat_t            q_stat,
    input  dmxm_pkg::light_t            q_head,
    output logic                        q_pop,
    input  logic                        pop,
    output logic                        empty,
    output logic [dmxm_pkg::PIX_W-1:0]  pixel_index,
    output logic [dmxm_pkg::BYTE_W-1:0] red,
    output logic [dmxm_pkg::BYTE_W-1:0] green,
    output logic [dmxm_pkg::BYTE_W-1:0] blue,
    output logic [dmxm_pkg::BYTE_W-1:0] white
);
    import dmxm_pkg::*;

    logic                    out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]        pixel_index_reg;
    logic [BYTE_W-1:0]       red_reg, green_reg, blue_reg, white_reg;
    logic [SUM_W-1:0]        rgb_sum;
    logic [MEAN_PROD_W-1:0]  mean_prod;
    logic [BYTE_W-1:0]       white_c;

    // Take a record when the result register is free or being emptied.
    assign q_pop = !q_stat.empty && (!out_valid_reg || pop);

    // Integer mean of three bytes by reciprocal multiply.
    assign rgb_sum   = SUM_W'(q_head.red) + SUM_W'(q_head.green) + SUM_W'(q_head.blue);
    assign mean_prod = MEAN_PROD_W'(rgb_sum) * MEAN_PROD_W'(MEAN_RECIP);
    assign white_c   = q_head.need_mean ? mean_prod[MEAN_SHIFT +: BYTE_W] : q_head.white;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            pixel_index_reg <= q_head.pixel_index;
            red_reg         <= q_head.red;
            green_reg       <= q_head.green;
            blue_reg        <= q_head.blue;
            white_reg       <= white_c;
        end
    end

    assign empty       = !out_valid_reg;
    assign pixel_index = pixel_index_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign white       = white_reg;

endmodule

>>> hdl/dmx_universe_pixel_mapper_core.sv
// Top level of the DMX universe pixel mapper: configuration registers and the three parts.
//
// The mapper takes one DMX slot byte per clock cycle while full is low, and writes at
// most one pixel per byte. The front part settles the packet and light state in the cycle
// the byte is taken, so a new byte may follow every cycle; a completed pixel reaches the
// result ports through the four-entry record queue and then the result register of the
// back part, which forms the RGB white mean with a reciprocal multiply. full rises
// only when four finished pixels wait in the queue behind an untaken result, and pop
// and push may move data in the same cycle. There is no clearing pass after reset.
module dmx_universe_pixel_mapper_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [dmxm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dmxm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [dmxm_pkg::UNI_W-1:0]      universe,
    input  logic [dmxm_pkg::BYTE_W-1:0]     slot_value,
    input  logic                            first_slot,
    output logic                            empty,
    input  logic                            pop,
    output logic [dmxm_pkg::PIX_W-1:0]      pixel_index,
    output logic [dmxm_pkg::BYTE_W-1:0]     red,
    output logic [dmxm_pkg::BYTE_W-1:0]     green,
    output logic [dmxm_pkg::BYTE_W-1:0]     blue,
    output logic [dmxm_pkg::BYTE_W-1:0]     white
);
    import dmxm_pkg::*;

    cfg_t    cfg_reg;
    logic    in_fire;
    logic    q_push;
    light_t  q_rec;
    light_t  q_head;
    logic    q_pop;
    qstat_t  q_stat;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_universe <= UNI_W'(1);
            cfg_reg.channel_mode   <= MODE_RGB;
            cfg_reg.strip_length   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FIRST_UNIVERSE: cfg_reg.first_universe <= cfg_data[UNI_W-1:0];
                REG_CHANNEL_MODE:   cfg_reg.channel_mode   <= cfg_data[MODE_W-1:0];
                REG_STRIP_LENGTH:   cfg_reg.strip_length   <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Input transfer.
    assign full    = q_stat.full;
    assign in_fire = push && !full;

    dmxm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_fire    (in_fire),
        .universe   (universe),
        .slot_value (slot_value),
        .first_slot (first_slot),
        .rec_push   (q_push),
        .rec        (q_rec)
    );

    dmxm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_push (q_push),
        .wr_rec  (q_rec),
        .rd_pop  (q_pop),
        .rd_rec  (q_head),
        .stat    (q_stat)
    );

    dmxm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .white       (white)
    );

    // A pixel record enters the queue only on an input transfer.
    a_push_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> in_fire)
        else $error("pixel record issued without an input transfer");

    // The queue is never written while it is full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("pixel queue written while full");

    // A waiting record refills the result register right after it is taken.
    a_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_stat.empty && (empty || pop)) |=> !empty)
        else $error("result register not refilled from the queue");

endmodule
